// ===== rtl/core/swsc_pkg.sv =====
// Package for the stereo window SAD cost block.
// Holds shared constants, register indexes and pipeline structs.
`timescale 1ns / 1ps

package swsc_pkg;

	localparam int DEF_WINDOW_RADIUS   = 2;
	localparam int DEF_MAX_WIDTH       = 1024;
	localparam int DEF_MAX_DISPARITIES = 64;

	localparam int HEIGHT_LIMIT = 1024;
	localparam int COORD_W      = 13;
	localparam int FED_W        = 24;
	localparam int OUT_COORD_W  = 10;
	localparam int DISP_W       = 6;
	localparam int NDISP_W      = 7;
	localparam int COST_W       = 16;

	localparam logic [COST_W-1:0] INVALID_COST = 16'hFF00;

	localparam logic [1:0] REG_IMAGE_WIDTH     = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT    = 2'd1;
	localparam logic [1:0] REG_MIN_DISPARITY   = 2'd2;
	localparam logic [1:0] REG_NUM_DISPARITIES = 2'd3;

	typedef struct packed {
		logic                   valid;
		logic                   emit;
		logic                   load_left;
		logic                   last;
		logic                   inval;
		logic [DISP_W-1:0]      disp;
		logic [OUT_COORD_W-1:0] col;
		logic [OUT_COORD_W-1:0] row;
	} meta_t;

	typedef struct packed {
		logic shift;
		logic load_left;
	} cell_ctl_t;

endpackage

// ===== rtl/core/stereo_window_sad_cost.sv =====
// Top level of the stereo window SAD cost block: line stores, sequencer,
// cell chain, sum and normalizer. Depends on swsc_pkg, swsc_cell, swsc_norm.
//
// Channel    Role     Moves
// s_*        slave    one pixel pair per transfer, tuser = padding flag
// m_*        master   one disparity cost per transfer, tlast = last of pixel
// p*         APB      configuration registers at byte addresses 0, 4, 8, 12
//
// An item that emits a center runs the column sequencer over num_disparities
// plus 2*WINDOW_RADIUS window columns, reading one per cycle from the row
// banks while the master side does not stall. Results pass the read, cell,
// column SAD, sum and normalizer registers. A stall on the master side
// freezes the whole pipe. Reset clears counters, sequencer and pipeline
// valid bits; the line stores are not cleared.
`timescale 1ns / 1ps

module stereo_window_sad_cost #(
	parameter int WINDOW_RADIUS   = swsc_pkg::DEF_WINDOW_RADIUS,
	parameter int MAX_WIDTH       = swsc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_DISPARITIES = swsc_pkg::DEF_MAX_DISPARITIES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // left_pixel [7:0], right_pixel [15:8]
	input  logic [0:0]  s_tuser,  // is_padding [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// center_col [9:0], center_row [19:10], disparity_index [25:20],
	// match_cost [41:26], zeros [47:42]
	output logic [47:0] m_tdata,
	output logic        m_tlast
);
	import swsc_pkg::*;

	localparam int WIN_SIDE = 2 * WINDOW_RADIUS + 1;
	localparam int AW       = $clog2(MAX_WIDTH);
	localparam int BANK_W   = $clog2(WIN_SIDE);
	localparam int SAD_W    = $clog2(WIN_SIDE * 255 + 1);
	localparam int SUM_W    = $clog2(WIN_SIDE * WIN_SIDE * 255 + 1);
	localparam int KW       = $clog2(MAX_DISPARITIES + 2 * WINDOW_RADIUS);
	localparam int SW       = COORD_W + 2;

	logic [10:0]        image_width_q;
	logic [10:0]        image_height_q;
	logic [9:0]         min_disp_q;
	logic [NDISP_W-1:0] num_disp_q;
	logic               cfg_wr;

	logic [COORD_W-1:0] w;
	logic [COORD_W-1:0] h;
	logic [NDISP_W-1:0] nd;
	logic [FED_W-1:0]   lag;
	logic [FED_W-1:0]   total;

	logic [COORD_W-1:0] col_q, row_q, cc_q, cr_q;
	logic [BANK_W-1:0]  bank_q;
	logic [FED_W-1:0]   fed_q;

	logic acc, pad, pixel_slot, take, emit_now, pos_ok, wr_px;

	logic               busy_q;
	logic [KW-1:0]      k_q;
	logic [KW-1:0]      kend;
	logic [COORD_W-1:0] job_cc_q, job_cr_q;
	logic               job_ok_q;
	logic               iss, en;

	logic [AW-1:0]        laddr, raddr;
	logic [KW-1:0]        d_idx;
	logic signed [SW-1:0] rc;
	logic                 rc_ok;
	meta_t                meta_next;

	logic [7:0] left_mem  [WIN_SIDE][MAX_WIDTH];
	logic [7:0] right_mem [WIN_SIDE][MAX_WIDTH];
	logic [WIN_SIDE-1:0][7:0] left_rd_s1, right_rd_s1;

	meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5, meta_s6, meta_s7;

	logic [WIN_SIDE-1:0][7:0] left_link  [WIN_SIDE+1];
	logic [WIN_SIDE-1:0][7:0] right_link [WIN_SIDE+1];
	logic [SAD_W-1:0]         col_sad [WIN_SIDE];
	cell_ctl_t                cell_ctl;
	logic [SUM_W-1:0]         sum_comb, sum_s4;
	logic [COST_W-1:0]        quot_s7, cost;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= 11'd640;
			image_height_q <= 11'd480;
			min_disp_q     <= 10'd0;
			num_disp_q     <= 7'd64;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_IMAGE_WIDTH:     image_width_q  <= pwdata[10:0];
				REG_IMAGE_HEIGHT:    image_height_q <= pwdata[10:0];
				REG_MIN_DISPARITY:   min_disp_q     <= pwdata[9:0];
				REG_NUM_DISPARITIES: num_disp_q     <= pwdata[6:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_IMAGE_WIDTH:     prdata = 32'(image_width_q);
			REG_IMAGE_HEIGHT:    prdata = 32'(image_height_q);
			REG_MIN_DISPARITY:   prdata = 32'(min_disp_q);
			REG_NUM_DISPARITIES: prdata = 32'(num_disp_q);
		endcase
	end

	always_comb begin
		if (image_width_q == 11'd0) begin
			w = COORD_W'(1);
		end else if (COORD_W'(image_width_q) > COORD_W'(MAX_WIDTH)) begin
			w = COORD_W'(MAX_WIDTH);
		end else begin
			w = COORD_W'(image_width_q);
		end
		if (image_height_q == 11'd0) begin
			h = COORD_W'(1);
		end else if (COORD_W'(image_height_q) > COORD_W'(HEIGHT_LIMIT)) begin
			h = COORD_W'(HEIGHT_LIMIT);
		end else begin
			h = COORD_W'(image_height_q);
		end
		if (num_disp_q == '0) begin
			nd = NDISP_W'(1);
		end else if (num_disp_q > NDISP_W'(MAX_DISPARITIES)) begin
			nd = NDISP_W'(MAX_DISPARITIES);
		end else begin
			nd = num_disp_q;
		end
	end

	assign lag   = FED_W'(WINDOW_RADIUS) * FED_W'(w) + FED_W'(WINDOW_RADIUS);
	assign total = FED_W'(h) * FED_W'(w) + lag;

	// Input side and frame position.
	assign s_tready   = !busy_q;
	assign acc        = s_tvalid & s_tready;
	assign pad        = s_tuser[0];
	assign pixel_slot = row_q < h;
	assign take       = acc && !(pixel_slot && pad);
	assign wr_px      = acc && pixel_slot && !pad;
	assign emit_now   = fed_q >= lag;
	assign pos_ok     = (cr_q >= COORD_W'(WINDOW_RADIUS)) &&
		(cr_q + COORD_W'(WINDOW_RADIUS) < h) &&
		(cc_q >= COORD_W'(WINDOW_RADIUS)) &&
		(cc_q + COORD_W'(WINDOW_RADIUS) < w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			cc_q   <= '0;
			cr_q   <= '0;
			bank_q <= '0;
			fed_q  <= '0;
		end else if (cfg_wr) begin
			col_q  <= '0;
			row_q  <= '0;
			cc_q   <= '0;
			cr_q   <= '0;
			bank_q <= '0;
			fed_q  <= '0;
		end else if (take) begin
			if (fed_q + FED_W'(1) >= total) begin
				col_q  <= '0;
				row_q  <= '0;
				cc_q   <= '0;
				cr_q   <= '0;
				bank_q <= '0;
				fed_q  <= '0;
			end else begin
				fed_q <= fed_q + FED_W'(1);
				if (col_q + COORD_W'(1) >= w) begin
					col_q  <= '0;
					row_q  <= row_q + COORD_W'(1);
					bank_q <= (bank_q == BANK_W'(WIN_SIDE - 1)) ? '0 :
						bank_q + BANK_W'(1);
				end else begin
					col_q <= col_q + COORD_W'(1);
				end
				if (emit_now) begin
					if (cc_q + COORD_W'(1) >= w) begin
						cc_q <= '0;
						cr_q <= cr_q + COORD_W'(1);
					end else begin
						cc_q <= cc_q + COORD_W'(1);
					end
				end
			end
		end
	end

	// Column sequencer.
	assign en   = !(meta_s7.valid && meta_s7.emit) || m_tready;
	assign iss  = busy_q && en;
	assign kend = KW'(nd) + KW'(2 * WINDOW_RADIUS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
		end else if (take && emit_now) begin
			busy_q <= 1'b1;
			k_q    <= '0;
		end else if (iss) begin
			if (k_q == kend) begin
				busy_q <= 1'b0;
			end
			k_q <= k_q + KW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit_now) begin
			job_cc_q <= cc_q;
			job_cr_q <= cr_q;
			job_ok_q <= pos_ok;
		end
	end

	assign laddr = AW'(job_cc_q + COORD_W'(WINDOW_RADIUS) - COORD_W'(k_q));
	assign raddr = AW'(job_cc_q - COORD_W'(min_disp_q) + COORD_W'(WINDOW_RADIUS) -
		COORD_W'(k_q));
	assign d_idx = k_q - KW'(2 * WINDOW_RADIUS);
	assign rc    = $signed(SW'(job_cc_q)) - $signed(SW'(min_disp_q)) -
		$signed(SW'(d_idx));
	assign rc_ok = (rc >= $signed(SW'(WINDOW_RADIUS))) &&
		((rc + $signed(SW'(WINDOW_RADIUS))) < $signed(SW'(w)));

	always_comb begin
		meta_next.valid     = iss;
		meta_next.emit      = k_q >= KW'(2 * WINDOW_RADIUS);
		meta_next.load_left = k_q < KW'(WIN_SIDE);
		meta_next.last      = k_q == kend;
		meta_next.inval     = !(job_ok_q && rc_ok);
		meta_next.disp      = DISP_W'(d_idx);
		meta_next.col       = job_cc_q[OUT_COORD_W-1:0];
		meta_next.row       = job_cr_q[OUT_COORD_W-1:0];
	end

	// Row-bank line stores.
	always_ff @(posedge clk) begin
		if (wr_px) begin
			left_mem[bank_q][col_q[AW-1:0]]  <= s_tdata[7:0];
			right_mem[bank_q][col_q[AW-1:0]] <= s_tdata[15:8];
		end
	end

	always_ff @(posedge clk) begin
		if (iss) begin
			for (int b = 0; b < WIN_SIDE; b++) begin
				left_rd_s1[b]  <= left_mem[b][laddr];
				right_rd_s1[b] <= right_mem[b][raddr];
			end
		end
	end

	// Pipeline control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
			meta_s2 <= '0;
			meta_s3 <= '0;
			meta_s4 <= '0;
			meta_s5 <= '0;
			meta_s6 <= '0;
			meta_s7 <= '0;
		end else if (en) begin
			meta_s1 <= meta_next;
			meta_s2 <= meta_s1;
			meta_s3 <= meta_s2;
			meta_s4 <= meta_s3;
			meta_s5 <= meta_s4;
			meta_s6 <= meta_s5;
			meta_s7 <= meta_s6;
		end
	end

	// Cell chain: right columns shift every step, left columns during load.
	assign cell_ctl.shift     = meta_s1.valid;
	assign cell_ctl.load_left = meta_s1.valid & meta_s1.load_left;
	assign left_link[0]       = left_rd_s1;
	assign right_link[0]      = right_rd_s1;

	for (genvar g = 0; g < WIN_SIDE; g++) begin : g_cell
		swsc_cell #(
			.WIN_SIDE (WIN_SIDE)
		) u_cell (
			.clk        (clk),
			.en         (en),
			.ctl        (cell_ctl),
			.left_in    (left_link[g]),
			.right_in   (right_link[g]),
			.left_out   (left_link[g+1]),
			.right_out  (right_link[g+1]),
			.col_sad_s3 (col_sad[g])
		);
	end

	always_comb begin
		sum_comb = '0;
		for (int i = 0; i < WIN_SIDE; i++) begin
			sum_comb = sum_comb + SUM_W'(col_sad[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s4 <= sum_comb;
		end
	end

	swsc_norm #(
		.WIN_SIDE (WIN_SIDE)
	) u_norm (
		.clk     (clk),
		.en      (en),
		.sum_s4  (sum_s4),
		.quot_s7 (quot_s7)
	);

	assign cost     = meta_s7.inval ? INVALID_COST : quot_s7;
	assign m_tvalid = meta_s7.valid & meta_s7.emit;
	assign m_tlast  = meta_s7.last;
	assign m_tdata  = {6'b0, cost, meta_s7.disp, meta_s7.row, meta_s7.col};

endmodule

// ===== rtl/core/swsc_cell.sv =====
// One column cell of the SAD chain: holds a left and a right window column.
// Depends on swsc_pkg for the control struct.
`timescale 1ns / 1ps

module swsc_cell #(
	parameter int WIN_SIDE = 5,
	localparam int SAD_W = $clog2(WIN_SIDE * 255 + 1)
) (
	input  logic                       clk,
	input  logic                       en,
	input  swsc_pkg::cell_ctl_t        ctl,
	input  logic [WIN_SIDE-1:0][7:0]   left_in,
	input  logic [WIN_SIDE-1:0][7:0]   right_in,
	output logic [WIN_SIDE-1:0][7:0]   left_out,
	output logic [WIN_SIDE-1:0][7:0]   right_out,
	output logic [SAD_W-1:0]           col_sad_s3
);
	import swsc_pkg::*;

	logic [WIN_SIDE-1:0][7:0] left_q;
	logic [WIN_SIDE-1:0][7:0] right_q;
	logic [SAD_W-1:0]         sad_sum;

	always_ff @(posedge clk) begin
		if (en && ctl.shift) begin
			right_q <= right_in;
			if (ctl.load_left) begin
				left_q <= left_in;
			end
		end
	end

	always_comb begin
		logic [7:0] diff;
		sad_sum = '0;
		for (int i = 0; i < WIN_SIDE; i++) begin
			diff = (left_q[i] > right_q[i]) ? (left_q[i] - right_q[i]) :
				(right_q[i] - left_q[i]);
			sad_sum = sad_sum + SAD_W'(diff);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			col_sad_s3 <= sad_sum;
		end
	end

	assign left_out  = left_q;
	assign right_out = right_q;

endmodule

// ===== rtl/core/swsc_norm.sv =====
// Normalizer: floor(sum * 256 / area) by reciprocal multiply and one correction.
// Depends on swsc_pkg for the cost width.
`timescale 1ns / 1ps

module swsc_norm #(
	parameter int WIN_SIDE = 5,
	localparam int SUM_W = $clog2(WIN_SIDE * WIN_SIDE * 255 + 1)
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [SUM_W-1:0]            sum_s4,
	output logic [swsc_pkg::COST_W-1:0] quot_s7
);
	import swsc_pkg::*;

	localparam int AREA   = WIN_SIDE * WIN_SIDE;
	localparam int X_W    = SUM_W + 8;
	localparam int PROD_W = X_W + 32;
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / AREA);

	logic [X_W-1:0]    x_in;
	logic [X_W-1:0]    x_s5;
	logic [X_W-1:0]    x_s6;
	logic [PROD_W-1:0] prod_s5;
	logic [COST_W-1:0] q0_s6;
	logic [X_W-1:0]    qa;
	logic [X_W-1:0]    rem;

	assign x_in = {sum_s4, 8'h00};

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s5 <= PROD_W'(x_in) * PROD_W'(RECIP);
			x_s5    <= x_in;
			q0_s6   <= COST_W'(prod_s5[PROD_W-1:32]);
			x_s6    <= x_s5;
		end
	end

	assign qa  = X_W'(X_W'(q0_s6) * X_W'(AREA));
	assign rem = x_s6 - qa;

	always_ff @(posedge clk) begin
		if (en) begin
			quot_s7 <= (rem >= X_W'(AREA)) ? (q0_s6 + COST_W'(1)) : q0_s6;
		end
	end

endmodule
